// File: rtl/core/lph_pkg.sv
// Shared types and constants for the linear probing hash insert block.
package lph_pkg;

	localparam int TABLE_SIZE  = 100;
	localparam int KEY_W       = 31;
	localparam int IDX_W       = $clog2(TABLE_SIZE);
	localparam int UC_W        = $clog2(TABLE_SIZE + 1);
	localparam int OUT_IDX_W   = 7;
	localparam int TOT_W       = 13;
	localparam int TOTAL_MAX   = 8191;
	localparam int QUEUE_DEPTH = 2;
	localparam int IN_DATA_W   = 32;
	localparam int OUT_DATA_W  = 40;

	// Reciprocal of TABLE_SIZE (100): key / 100 == (key * MOD_MUL) >> MOD_SHIFT for any
	// 32-bit key.
	localparam int          MUL_W     = 64;
	localparam logic [31:0] MOD_MUL   = 32'h51EB_851F;
	localparam int          MOD_SHIFT = 37;
	localparam int          QUOT_W    = MUL_W - MOD_SHIFT;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_CLEAR  = 1'b1;

	// One classified item on its way from the front to the back.
	typedef struct packed {
		logic             action;
		logic [KEY_W-1:0] key;
		logic [IDX_W-1:0] home;
	} lph_entry_t;

	// One result item.
	typedef struct packed {
		logic                 table_full;
		logic [TOT_W-1:0]     running_total;
		logic [OUT_IDX_W-1:0] misses;
		logic [OUT_IDX_W-1:0] final_index;
		logic [OUT_IDX_W-1:0] home_index;
	} lph_res_t;

	// Fit an internal index or count to the fixed field width (mask or zero-extend).
	function automatic logic [OUT_IDX_W-1:0] to_field(input logic [IDX_W-1:0] v);
		logic [IDX_W+OUT_IDX_W-1:0] ext;
		ext = {{OUT_IDX_W{1'b0}}, v};
		return ext[OUT_IDX_W-1:0];
	endfunction

endpackage

// File: rtl/core/linear_probe_hash_insert.sv
// Top level of the linear probing hash table insert block.
//
// Usage: items arrive on the s_ group; tuser selects insert (0) or clear (1) and tdata carries
// the key. Each item yields exactly one result on the m_ group.
// The front takes one item, then reduces the key modulo the table size by a reciprocal
// multiply and a multiply-back subtract (skipped for a clear), and pushes it into a
// two-entry queue. s_tready rises again once the item is queued, so the front takes no new
// item while it is still working on the last one.
// The back pops an item and probes the used bits one slot per cycle starting at the home slot:
// an insert probes until it finds a free slot, a clear or an insert into a full table skips
// the probe and goes straight to emit, then the result moves to the output register.
// The probe loop reads a single slot at a time and bounds the sustained insert rate.
// A full table sets table_full and stores nothing. A clear empties all slots and the miss
// total at once, as the used bits live in flip-flops.
// Reset empties the table, the total, the queue and the output register.
// When m_tready is low the result holds; the back finishes its next item and waits, the queue
// fills, and then the front holds s_tready low.
module linear_probe_hash_insert import lph_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // [30:0] key, [31] zero
	input  logic                  s_tuser,   // [0] action
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata    // [6:0] home_index, [13:7] final_index,
	                                         // [20:14] misses, [33:21] running_total,
	                                         // [34] table_full, [39:35] zero
);

	lph_entry_t push_entry;
	lph_entry_t q_head;
	lph_res_t   res;
	logic       push;
	logic       q_full;
	logic       q_valid;
	logic       pop;

	// Classify and compute the home slot.
	lph_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_action  (s_tuser),
		.in_key     (s_tdata[KEY_W-1:0]),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full)
	);

	// Decouple the key reduction from the probe loop.
	lph_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.valid      (q_valid),
		.head       (q_head)
	);

	// Probe, store and report.
	lph_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pack the result fields from the lowest bit up and pad to whole bytes.
	assign m_tdata = {(OUT_DATA_W - $bits(lph_res_t))'(0), res};

	// A full-table result stores nothing, so it reports no slot and no misses.
	a_full_no_probe: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[34]) |-> (m_tdata[20:7] == '0))
		else $error("full-table result carries probe data");

	// A stalled result holds its data until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

	// The front takes one item at a time: after an acceptance it is busy.
	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("front accepted back to back");

	// Slot indices and miss counts stay inside the table.
	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (res.home_index < OUT_IDX_W'(TABLE_SIZE) &&
		              res.final_index < OUT_IDX_W'(TABLE_SIZE) &&
		              res.misses < OUT_IDX_W'(TABLE_SIZE)))
		else $error("result index out of range");

endmodule

// File: rtl/core/lph_front.sv
// Front end: accept items and reduce the key to its home slot by reciprocal multiplication.
module lph_front import lph_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             in_action,
	input  logic [KEY_W-1:0] in_key,
	output logic             push,
	output lph_entry_t       push_entry,
	input  logic             q_full
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_REM  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t           state_q;
	logic              action_q;
	logic [KEY_W-1:0]  key_q;
	logic [QUOT_W-1:0] quot_q;
	logic [IDX_W-1:0]  rem_q;
	logic [MUL_W-1:0]  prod;
	logic [KEY_W-1:0]  quot_x;
	logic [KEY_W-1:0]  rem_full;

	// Quotient by the reciprocal, then the remainder by one multiply-back and subtract.
	always_comb begin
		prod     = MUL_W'(key_q) * MUL_W'(MOD_MUL);
		quot_x   = KEY_W'(quot_q) * KEY_W'(TABLE_SIZE);
		rem_full = key_q - quot_x;
	end

	assign in_ready   = (state_q == F_IDLE);
	assign push       = (state_q == F_PUSH) && !q_full;
	assign push_entry = '{action: action_q, key: key_q, home: rem_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						state_q <= (in_action == ACT_CLEAR) ? F_PUSH : F_MUL;
					end
				end
				F_MUL: begin
					state_q <= F_REM;
				end
				F_REM: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			action_q <= in_action;
			key_q    <= in_key;
			rem_q    <= '0;
		end else if (state_q == F_MUL) begin
			quot_q <= prod[MUL_W-1:MOD_SHIFT];
		end else if (state_q == F_REM) begin
			rem_q <= rem_full[IDX_W-1:0];
		end
	end

endmodule

// File: rtl/core/lph_queue.sv
// Short FIFO of classified items between the front and the back.
module lph_queue import lph_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  lph_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       valid,
	output lph_entry_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	lph_entry_t        entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// File: rtl/core/lph_back.sv
// Back end: probe the table one slot per cycle, store the key, hold the result register.
module lph_back import lph_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  lph_entry_t q_head,
	output logic       pop,
	output logic       res_valid,
	input  logic       res_ready,
	output lph_res_t   res
);

	typedef enum logic [2:0] {
		B_IDLE  = 3'b001,
		B_PROBE = 3'b010,
		B_EMIT  = 3'b100
	} bstate_t;

	bstate_t           state_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  home_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  miss_q;
	logic [UC_W-1:0]   used_cnt_q;
	logic [TOT_W-1:0]  total_q;
	logic [TABLE_SIZE-1:0] used_q;
	logic [KEY_W-1:0]  key_mem [TABLE_SIZE];
	lph_res_t          pend_q;
	lph_res_t          res_q;
	logic              res_valid_q;
	logic [TOT_W:0]    total_sum;
	logic [TOT_W-1:0]  total_new;
	logic              slot_free;
	logic              emit;

	assign slot_free = !used_q[idx_q];
	assign pop       = (state_q == B_IDLE) && q_valid;
	assign emit      = (state_q == B_EMIT) && (!res_valid_q || res_ready);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Saturating accumulate of this insert's misses.
	always_comb begin
		total_sum = {1'b0, total_q} + (TOT_W+1)'(miss_q);
		if (total_sum > (TOT_W+1)'(TOTAL_MAX)) begin
			total_new = TOT_W'(TOTAL_MAX);
		end else begin
			total_new = total_sum[TOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			used_q      <= '0;
			used_cnt_q  <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						if (q_head.action == ACT_CLEAR) begin
							used_q     <= '0;
							used_cnt_q <= '0;
							total_q    <= '0;
							state_q    <= B_EMIT;
						end else if (used_cnt_q == UC_W'(TABLE_SIZE)) begin
							state_q <= B_EMIT;
						end else begin
							state_q <= B_PROBE;
						end
					end
				end
				B_PROBE: begin
					if (slot_free) begin
						used_q[idx_q] <= 1'b1;
						used_cnt_q    <= used_cnt_q + 1'b1;
						total_q       <= total_new;
						state_q       <= B_EMIT;
					end
				end
				B_EMIT: begin
					if (emit) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					key_q  <= q_head.key;
					home_q <= q_head.home;
					idx_q  <= q_head.home;
					miss_q <= '0;
					if (q_head.action == ACT_CLEAR) begin
						pend_q <= '0;
					end else begin
						pend_q.home_index    <= to_field(q_head.home);
						pend_q.final_index   <= '0;
						pend_q.misses        <= '0;
						pend_q.running_total <= total_q;
						pend_q.table_full    <= 1'b1;
					end
				end
			end
			B_PROBE: begin
				if (slot_free) begin
					key_mem[idx_q]       <= key_q;
					pend_q.home_index    <= to_field(home_q);
					pend_q.final_index   <= to_field(idx_q);
					pend_q.misses        <= to_field(miss_q);
					pend_q.running_total <= total_new;
					pend_q.table_full    <= 1'b0;
				end else begin
					miss_q <= miss_q + 1'b1;
					idx_q  <= (idx_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
				end
			end
			B_EMIT: begin
				if (emit) begin
					res_q <= pend_q;
				end
			end
			default: ;
		endcase
	end

endmodule
